### rtl/necd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// necd_pkg: shared types and constants for the NEC IR frame decoder
// Interval thresholds, item kinds, result status codes and queue defaults.
// ----------------------------------------------------------------------------
package necd_pkg;

  localparam int INTERVAL_W  = 14;
  localparam int FRAME_BITS  = 32;
  localparam int BITCNT_W    = 6;
  localparam int REPEAT_W    = 16;
  localparam int ADDR_W      = 16;
  localparam int CMD_W       = 8;
  localparam int QUEUE_DEPTH = 4;

  // burst length, subtracted from each interval to get the space time
  localparam int BURST_US = 560;

  // strict gap bounds, re-based to the raw interval (gap + burst)
  localparam logic [INTERVAL_W-1:0] BIT0_LO   = INTERVAL_W'(BURST_US + 300);
  localparam logic [INTERVAL_W-1:0] BIT0_HI   = INTERVAL_W'(BURST_US + 800);
  localparam logic [INTERVAL_W-1:0] BIT1_LO   = INTERVAL_W'(BURST_US + 1400);
  localparam logic [INTERVAL_W-1:0] BIT1_HI   = INTERVAL_W'(BURST_US + 1800);
  localparam logic [INTERVAL_W-1:0] REPEAT_LO = INTERVAL_W'(BURST_US + 2200);
  localparam logic [INTERVAL_W-1:0] REPEAT_HI = INTERVAL_W'(BURST_US + 2600);
  localparam logic [INTERVAL_W-1:0] LEADER_LO = INTERVAL_W'(BURST_US + 4200);
  localparam logic [INTERVAL_W-1:0] LEADER_HI = INTERVAL_W'(BURST_US + 5000);

  localparam logic [BITCNT_W-1:0] BITCNT_FULL = BITCNT_W'(FRAME_BITS);
  localparam logic [REPEAT_W-1:0] REPEAT_MAX  = {REPEAT_W{1'b1}};

  // input func codes
  localparam logic FUNC_EDGE = 1'b0;

  typedef enum logic [2:0] {
    K_IGNORE = 3'd0,
    K_BIT0   = 3'd1,
    K_BIT1   = 3'd2,
    K_REPEAT = 3'd3,
    K_LEADER = 3'd4,
    K_TICK   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CHECK_FAIL = 2'd1,
    ST_REPEAT     = 2'd2
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t kind;
  } item_t;

endpackage : necd_pkg
`default_nettype wire

### rtl/necd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// necd_front: input transaction classifier
// Turns an edge interval or a timeout tick into one item kind for the queue.
// ----------------------------------------------------------------------------
module necd_front (
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  input  wire logic                          in_func,
  input  wire logic [necd_pkg::INTERVAL_W-1:0] in_interval,
  output      logic                          push_valid,
  input  wire logic                          push_ready,
  output      necd_pkg::item_t               push_item
);

  logic [necd_pkg::INTERVAL_W-1:0] cap;

  assign cap        = in_interval;
  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

  // intervals under the burst length fall outside every window
  always_comb begin
    push_item.kind = necd_pkg::K_IGNORE;
    if (in_func != necd_pkg::FUNC_EDGE) begin
      push_item.kind = necd_pkg::K_TICK;
    end else if (cap > necd_pkg::BIT0_LO && cap < necd_pkg::BIT0_HI) begin
      push_item.kind = necd_pkg::K_BIT0;
    end else if (cap > necd_pkg::BIT1_LO && cap < necd_pkg::BIT1_HI) begin
      push_item.kind = necd_pkg::K_BIT1;
    end else if (cap > necd_pkg::REPEAT_LO && cap < necd_pkg::REPEAT_HI) begin
      push_item.kind = necd_pkg::K_REPEAT;
    end else if (cap > necd_pkg::LEADER_LO && cap < necd_pkg::LEADER_HI) begin
      push_item.kind = necd_pkg::K_LEADER;
    end
  end

endmodule : necd_front
`default_nettype wire

### rtl/necd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// necd_queue: small item FIFO between classifier and frame engine
// Register-based ring buffer; head entry is visible combinationally.
// ----------------------------------------------------------------------------
module necd_queue #(
  parameter int DEPTH = necd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output      logic            push_ready,
  input  wire necd_pkg::item_t push_item,
  output      logic            pop_valid,
  input  wire logic            pop_ready,
  output      necd_pkg::item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  necd_pkg::item_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule : necd_queue
`default_nettype wire

### rtl/necd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// necd_back: NEC frame engine
// Tracks arming, leader, shift register and repeat count; registers results.
// ----------------------------------------------------------------------------
module necd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pop_valid,
  output      logic            pop_ready,
  input  wire necd_pkg::item_t pop_item,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      necd_pkg::status_t                out_status,
  output      logic [necd_pkg::ADDR_W-1:0]      out_address,
  output      logic [necd_pkg::CMD_W-1:0]       out_command,
  output      logic                             out_extended,
  output      logic [necd_pkg::FRAME_BITS-1:0]  out_raw,
  output      logic [necd_pkg::REPEAT_W-1:0]    out_repeats
);

  logic                            armed_r, armed_nxt;
  logic                            leader_r, leader_nxt;
  logic [necd_pkg::FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [necd_pkg::BITCNT_W-1:0]   bitcnt_r, bitcnt_nxt;
  logic [necd_pkg::REPEAT_W-1:0]   repeats_r, repeats_nxt;
  logic                            out_valid_r, out_valid_nxt;

  necd_pkg::status_t               status_r, res_status;
  logic [necd_pkg::ADDR_W-1:0]     address_r, res_address;
  logic [necd_pkg::CMD_W-1:0]      command_r, res_command;
  logic                            extended_r, res_extended;
  logic [necd_pkg::FRAME_BITS-1:0] raw_r, res_raw;
  logic [necd_pkg::REPEAT_W-1:0]   repcnt_r;

  logic                            do_pop, res_valid;
  logic [necd_pkg::FRAME_BITS-1:0] shifted;
  logic [7:0]                      b1, b2, b3, b4;

  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;

  assign shifted = {(pop_item.kind == necd_pkg::K_BIT1), shift_r[necd_pkg::FRAME_BITS-1:1]};
  assign b1 = shifted[7:0];
  assign b2 = shifted[15:8];
  assign b3 = shifted[23:16];
  assign b4 = shifted[31:24];

  always_comb begin
    armed_nxt    = armed_r;
    leader_nxt   = leader_r;
    shift_nxt    = shift_r;
    bitcnt_nxt   = bitcnt_r;
    repeats_nxt  = repeats_r;
    res_valid    = 1'b0;
    res_status   = necd_pkg::ST_OK;
    res_address  = '0;
    res_command  = '0;
    res_extended = 1'b0;
    res_raw      = '0;
    if (do_pop) begin
      if (pop_item.kind == necd_pkg::K_TICK) begin
        if (leader_r) begin
          armed_nxt  = 1'b0;
          leader_nxt = 1'b0;
          bitcnt_nxt = '0;
        end
      end else if (!armed_r) begin
        armed_nxt = 1'b1;
      end else begin
        unique case (pop_item.kind) inside
          necd_pkg::K_BIT0, necd_pkg::K_BIT1: begin
            if (leader_r && bitcnt_r < necd_pkg::BITCNT_FULL) begin
              shift_nxt  = shifted;
              bitcnt_nxt = bitcnt_r + 1'b1;
              if (bitcnt_nxt == necd_pkg::BITCNT_FULL) begin
                leader_nxt = 1'b0;
                shift_nxt  = '0;
                res_valid  = 1'b1;
                res_raw    = shifted;
                if (b3 != ~b4) begin
                  res_status = necd_pkg::ST_CHECK_FAIL;
                end else if (b1 != ~b2) begin
                  res_address  = {b2, b1};
                  res_command  = b3;
                  res_extended = 1'b1;
                end else begin
                  res_address = {8'h00, b1};
                  res_command = b3;
                end
              end
            end
          end
          necd_pkg::K_REPEAT: begin
            if (repeats_r != necd_pkg::REPEAT_MAX) begin
              repeats_nxt = repeats_r + 1'b1;
            end
            res_valid  = 1'b1;
            res_status = necd_pkg::ST_REPEAT;
          end
          necd_pkg::K_LEADER: begin
            shift_nxt   = '0;
            bitcnt_nxt  = '0;
            leader_nxt  = 1'b1;
            repeats_nxt = '0;
          end
          default: begin
          end
        endcase
      end
    end
    if (do_pop && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      leader_r    <= 1'b0;
      shift_r     <= '0;
      bitcnt_r    <= '0;
      repeats_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      leader_r    <= leader_nxt;
      shift_r     <= shift_nxt;
      bitcnt_r    <= bitcnt_nxt;
      repeats_r   <= repeats_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only when a new result is produced
  always_ff @(posedge clk) begin
    if (do_pop && res_valid) begin
      status_r   <= res_status;
      address_r  <= res_address;
      command_r  <= res_command;
      extended_r <= res_extended;
      raw_r      <= res_raw;
      repcnt_r   <= repeats_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_address  = address_r;
  assign out_command  = command_r;
  assign out_extended = extended_r;
  assign out_raw      = raw_r;
  assign out_repeats  = repcnt_r;

  a_bitcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bitcnt_r <= necd_pkg::BITCNT_FULL) else $error("bit count past frame length");

  a_leader_open: assert property (@(posedge clk) disable iff (!rst_n)
    leader_r |-> (bitcnt_r < necd_pkg::BITCNT_FULL))
    else $error("frame still open with all bits received");

  a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == necd_pkg::ST_REPEAT) |-> (repcnt_r != '0))
    else $error("repeat result with zero count");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !do_pop)
    else $error("item consumed while result stalled");

endmodule : necd_back
`default_nettype wire

### rtl/nec_ir_frame_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top: NEC infrared remote frame decoder
// Input stream: one transaction per captured rising edge or timeout tick.
//   in_tuser = func (0 edge, 1 timeout), in_tdata[13:0] = interval in us.
// Output stream: one transaction per decoded frame, failed check or repeat.
//   out_tuser = status, out_tdata carries address, command, extended flag,
//   raw 32-bit frame and saturating repeat count.
// A classifier accepts and tags each transaction and pushes it into a
// QUEUE_DEPTH-entry FIFO; the frame engine pops one entry per cycle while no
// result is stalled. Throughput: one input transaction per cycle under the same
// condition. An accepted input reaches out_tvalid through the queue slot and
// then the output register.
// When out_tready is low the result register holds, the engine stops popping
// and in_tready drops once the FIFO fills; nothing is lost.
// Reset (rst_n low, synchronous) empties the FIFO, drops any pending result
// and clears the arming, leader, bit count, shift data and repeat count.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top #(
  parameter int QUEUE_DEPTH = necd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [13:0] interval_us, [15:14] zero
  input  wire logic        in_tuser,   // [0] func
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [79:0] out_tdata,  // [15:0] address, [23:16] command,
                                       // [24] extended, [56:25] raw_frame,
                                       // [72:57] repeat_count, [79:73] zero
  output      logic [1:0]  out_tuser   // [1:0] status
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  necd_pkg::item_t push_item, pop_item;

  necd_pkg::status_t                res_status;
  logic [necd_pkg::ADDR_W-1:0]      res_address;
  logic [necd_pkg::CMD_W-1:0]       res_command;
  logic                             res_extended;
  logic [necd_pkg::FRAME_BITS-1:0]  res_raw;
  logic [necd_pkg::REPEAT_W-1:0]    res_repeats;

  necd_front u_front (
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_func     (in_tuser),
    .in_interval (in_tdata[necd_pkg::INTERVAL_W-1:0]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  necd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  necd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (res_status),
    .out_address  (res_address),
    .out_command  (res_command),
    .out_extended (res_extended),
    .out_raw      (res_raw),
    .out_repeats  (res_repeats)
  );

  assign out_tuser = res_status;
  assign out_tdata = {7'b0, res_repeats, res_raw, res_extended, res_command, res_address};

endmodule : nec_ir_frame_decoder_top
`default_nettype wire

### test/tb_nec_ir_frame_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nec_ir_frame_decoder_top: self-checking bench for the NEC IR decoder
// Drives edge/timeout transactions with random idle gaps and checks every
// result against an in-bench decoder model. Covers gap boundaries, bits with
// no leader, stop bits, extended and failed frames, timeout ticks, repeat
// bursts and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_nec_ir_frame_decoder_top;

  localparam int BURST_US      = 560;
  localparam int BIT0_GAP_LO   = 300;
  localparam int BIT0_GAP_HI   = 800;
  localparam int BIT1_GAP_LO   = 1400;
  localparam int BIT1_GAP_HI   = 1800;
  localparam int REP_GAP_LO    = 2200;
  localparam int REP_GAP_HI    = 2600;
  localparam int LDR_GAP_LO    = 4200;
  localparam int LDR_GAP_HI    = 5000;
  localparam int INTERVAL_MAX  = 10000;
  localparam int FRAME_LEN     = 32;
  localparam int RANDOM_ITEMS  = 900;
  localparam int BURST_REPEATS = 120;
  localparam int HOLD_CYCLES   = 400;

  localparam logic FUNC_EDGE = necd_pkg::FUNC_EDGE;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum int {GAP_NONE, GAP_BIT0, GAP_BIT1, GAP_REPEAT, GAP_LEADER} gap_class_t;
  typedef enum int {FR_NORMAL, FR_EXTENDED, FR_BAD} frame_kind_t;

  typedef struct packed {
    necd_pkg::status_t status;
    logic [15:0]       address;
    logic [7:0]        command;
    logic              extended;
    logic [31:0]       raw_frame;
    logic [15:0]       repeat_count;
  } nec_result_t;

  class nec_frame_scoreboard;
    bit          armed;
    bit          in_frame;
    logic [31:0] shift_bits;
    int unsigned bits_in;
    logic [15:0] repeat_cnt;
    nec_result_t expected_frames[$];
    int          mismatches;

    function gap_class_t classify(int g);
      if (g > BIT0_GAP_LO && g < BIT0_GAP_HI) return GAP_BIT0;
      if (g > BIT1_GAP_LO && g < BIT1_GAP_HI) return GAP_BIT1;
      if (g > REP_GAP_LO && g < REP_GAP_HI) return GAP_REPEAT;
      if (g > LDR_GAP_LO && g < LDR_GAP_HI) return GAP_LEADER;
      return GAP_NONE;
    endfunction

    // mirror of the decoder state; queues the result this transaction causes
    function void decode_item(logic func, logic [13:0] interval);
      gap_class_t  cls;
      nec_result_t r;
      logic [7:0]  b1, b2, b3, b4;
      if (func == FUNC_TICK) begin
        if (in_frame) begin
          armed    = 1'b0;
          in_frame = 1'b0;
          bits_in  = 0;
        end
        return;
      end
      if (!armed) begin
        armed = 1'b1;
        return;
      end
      if (interval < BURST_US) return;
      cls = classify(int'(interval) - BURST_US);
      r = '0;
      case (cls)
        GAP_BIT0, GAP_BIT1: begin
          if (!in_frame || bits_in >= FRAME_LEN) return;
          shift_bits = {cls == GAP_BIT1, shift_bits[31:1]};
          bits_in++;
          if (bits_in < FRAME_LEN) return;
          {b4, b3, b2, b1} = shift_bits;
          in_frame = 1'b0;
          r.raw_frame    = shift_bits;
          r.repeat_count = repeat_cnt;
          shift_bits = '0;
          if (b3 != ~b4) begin
            r.status = necd_pkg::ST_CHECK_FAIL;
          end else begin
            r.status  = necd_pkg::ST_OK;
            r.command = b3;
            if (b1 != ~b2) begin
              r.address  = {b2, b1};
              r.extended = 1'b1;
            end else begin
              r.address = {8'h00, b1};
            end
          end
          expected_frames.push_back(r);
        end
        GAP_REPEAT: begin
          if (repeat_cnt != 16'hFFFF) repeat_cnt++;
          r.status       = necd_pkg::ST_REPEAT;
          r.repeat_count = repeat_cnt;
          expected_frames.push_back(r);
        end
        GAP_LEADER: begin
          shift_bits = '0;
          bits_in    = 0;
          in_frame   = 1'b1;
          repeat_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task check_frame_result(logic [1:0] st, logic [79:0] d);
      nec_result_t want;
      if (expected_frames.size() == 0) begin
        report("unexpected result, status", st, 0);
        return;
      end
      want = expected_frames.pop_front();
      if (st !== want.status) report("status", st, want.status);
      if (d[15:0] !== want.address) report("address", d[15:0], want.address);
      if (d[23:16] !== want.command) report("command", d[23:16], want.command);
      if (d[24] !== want.extended) report("extended", d[24], want.extended);
      if (d[56:25] !== want.raw_frame) report("raw_frame", d[56:25], want.raw_frame);
      if (d[72:57] !== want.repeat_count)
        report("repeat_count", d[72:57], want.repeat_count);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;

  nec_frame_scoreboard sb;
  int unsigned         items_sent;
  bit                  tx_steady;
  logic                rx_steady;
  logic                hold_req;
  int unsigned         rx_wait;
  int unsigned         hold_left;
  bit                  hold_done;

  nec_ir_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_interval(gap_class_t cls);
    case (cls)
      GAP_BIT0:   return $urandom_range(BURST_US + BIT0_GAP_LO + 1, BURST_US + BIT0_GAP_HI - 1);
      GAP_BIT1:   return $urandom_range(BURST_US + BIT1_GAP_LO + 1, BURST_US + BIT1_GAP_HI - 1);
      GAP_REPEAT: return $urandom_range(BURST_US + REP_GAP_LO + 1, BURST_US + REP_GAP_HI - 1);
      GAP_LEADER: return $urandom_range(BURST_US + LDR_GAP_LO + 1, BURST_US + LDR_GAP_HI - 1);
      default: begin
        case ($urandom_range(5))
          0: return $urandom_range(0, BURST_US - 1);
          1: return $urandom_range(BURST_US, BURST_US + BIT0_GAP_LO);
          2: return $urandom_range(BURST_US + BIT0_GAP_HI, BURST_US + BIT1_GAP_LO);
          3: return $urandom_range(BURST_US + BIT1_GAP_HI, BURST_US + REP_GAP_LO);
          4: return $urandom_range(BURST_US + REP_GAP_HI, BURST_US + LDR_GAP_LO);
          default: return $urandom_range(BURST_US + LDR_GAP_HI, INTERVAL_MAX);
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] make_frame(frame_kind_t kind);
    logic [7:0] a, c, flip;
    a    = 8'($urandom_range(255));
    c    = 8'($urandom_range(255));
    flip = 8'($urandom_range(1, 255));
    case (kind)
      FR_EXTENDED: return {~c, c, ~a ^ flip, a};
      FR_BAD:      return {~c ^ flip, c, 8'($urandom_range(255)), a};
      default:     return {~c, c, ~a, a};
    endcase
  endfunction

  task automatic send_item(input logic func, input logic [13:0] interval);
    int unsigned idle;
    idle = tx_steady ? 0 : pick_gap();
    if (idle != 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {2'b00, interval};
    do @(posedge clk); while (!in_tready);
    sb.decode_item(func, interval);
    items_sent++;
  endtask

  task automatic send_edge(input int interval);
    send_item(FUNC_EDGE, 14'(interval));
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, 14'($urandom_range(0, INTERVAL_MAX)));
  endtask

  task automatic send_frame(input logic [31:0] raw, input int nbits);
    send_edge(rand_interval(GAP_LEADER));
    for (int i = 0; i < nbits; i++)
      send_edge(rand_interval(raw[i] ? GAP_BIT1 : GAP_BIT0));
  endtask

  // result side: random back-pressure plus one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (rx_wait != 0) begin
      out_tready <= 1'b0;
      rx_wait    <= rx_wait - 1;
    end else if (rx_steady || $urandom_range(99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      rx_wait    <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame_result(out_tuser, out_tdata);
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_end;
    int unsigned drain;
    int unsigned r;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_EDGE;
    rx_steady  = 1'b0;
    hold_req   = 1'b0;
    tx_steady  = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first edge only arms, then the gap boundaries with no leader around
    send_edge(0);
    send_edge(BURST_US - 1);
    send_edge(BURST_US);
    send_edge(BURST_US + BIT0_GAP_LO);
    send_edge(BURST_US + BIT0_GAP_LO + 1);
    send_edge(BURST_US + BIT0_GAP_HI - 1);
    send_edge(BURST_US + BIT0_GAP_HI);
    send_edge(BURST_US + BIT1_GAP_LO);
    send_edge(BURST_US + BIT1_GAP_LO + 1);
    send_edge(BURST_US + BIT1_GAP_HI - 1);
    send_edge(BURST_US + BIT1_GAP_HI);
    send_edge(BURST_US + REP_GAP_LO);
    send_edge(BURST_US + REP_GAP_LO + 1);
    send_edge(BURST_US + REP_GAP_HI - 1);
    send_edge(BURST_US + REP_GAP_HI);
    send_edge(BURST_US + LDR_GAP_LO);
    send_edge(BURST_US + LDR_GAP_LO + 1);
    send_edge(BURST_US + LDR_GAP_HI - 1);
    send_edge(BURST_US + LDR_GAP_HI);
    send_edge(INTERVAL_MAX);
    // tick inside a frame disarms; a tick when idle does nothing
    send_tick();
    send_edge(BURST_US + REP_GAP_LO + 1);
    send_edge(BURST_US + REP_GAP_HI - 1);
    send_tick();
    send_edge('h2000);

    // back-to-back repeat burst, with a long output hold at its start
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    hold_req  <= 1'b1;
    repeat (BURST_REPEATS) send_edge(rand_interval(GAP_REPEAT));
    tx_steady = 1'b0;
    rx_steady <= 1'b0;

    rand_end = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_end) begin
      r = $urandom_range(99);
      if (r < 70) begin
        r = $urandom_range(3);
        send_frame(make_frame(r == 0 ? FR_BAD : r == 1 ? FR_EXTENDED : FR_NORMAL),
                   FRAME_LEN);
        if ($urandom_range(1)) send_edge(rand_interval(GAP_BIT0));
        repeat ($urandom_range(0, 3)) send_edge(rand_interval(GAP_REPEAT));
        if ($urandom_range(9) == 0) send_edge(rand_interval(GAP_NONE));
      end else if (r < 82) begin
        // broken frame: cut short by a tick, by noise or by whatever item follows
        send_frame($urandom(), $urandom_range(0, FRAME_LEN - 1));
        case ($urandom_range(2))
          0: begin
            send_tick();
            send_edge(rand_interval(GAP_NONE));
          end
          1: send_edge(rand_interval(GAP_NONE));
          default: ;
        endcase
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_edge(rand_interval(GAP_REPEAT));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(3) == 0) send_tick();
          else if ($urandom_range(1)) send_edge($urandom_range(0, INTERVAL_MAX));
          else send_edge(rand_interval(GAP_NONE));
        end
      end
    end
    in_tvalid <= 1'b0;

    rx_steady <= 1'b1;
    drain = 0;
    while (sb.expected_frames.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (sb.expected_frames.size() != 0)
      sb.report("results never delivered, count", sb.expected_frames.size(), 0);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
